@@ src/prefix_code_byte_decoder_defines.svh @@
// Assertion macros for the checker file.
// The clock is taken as i_clk in the scope where a macro is used.
`ifndef PREFIX_CODE_BYTE_DECODER_DEFINES_SVH
`define PREFIX_CODE_BYTE_DECODER_DEFINES_SVH

// Same-cycle implication
`define PCBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PCBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pcbd_pkg.sv @@
`default_nettype none

package pcbd_pkg;

    // Symbol codes
    localparam logic [1:0] SYM_A = 2'd0;
    localparam logic [1:0] SYM_B = 2'd1;
    localparam logic [1:0] SYM_C = 2'd2;
    localparam logic [1:0] SYM_D = 2'd3;

    // Bit window: three carried bits plus one byte
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CARRY_W = 3;
    localparam int unsigned WIN_W   = BYTE_W + CARRY_W;
    localparam int unsigned CNT_W   = 4;

    // One queued byte
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              message_end;
    } t_item;

    // Outcome of one decode step
    typedef enum logic [1:0] {
        STEP_EMIT,
        STEP_DROP,
        STEP_STOP
    } t_step;

endpackage

`default_nettype wire

@@ src/pcbd_front.sv @@
`default_nettype none

module pcbd_front import pcbd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BYTE_W-1:0] i_packed_byte,
    input  wire logic              i_message_end,
    output t_item                  o_item,
    output logic                   o_item_vld,
    input  wire logic              i_pop
);

    localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_stall    = (r_count == FILL_W'(DEPTH));
    assign o_item_vld = (r_count != '0);
    assign push       = i_valid && !o_stall;
    assign pop        = i_pop && o_item_vld;
    assign o_item     = r_mem[r_rd_ptr];

    // Store accepted bytes
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{packed_byte: i_packed_byte, message_end: i_message_end};
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/pcbd_back.sv @@
`default_nettype none

module pcbd_back import pcbd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_item           i_item,
    input  wire logic       i_item_vld,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_symbol,
    output logic            o_last_of_byte
);

    // Bit window, left aligned; bits below the count are zero
    logic [WIN_W-1:0] r_q;
    logic [CNT_W-1:0] r_n;
    logic             r_busy;
    logic             r_end;
    logic             r_hold_vld;
    logic [1:0]       r_hold_sym;
    logic             r_out_vld;
    logic [1:0]       r_out_sym;
    logic             r_out_last;

    logic [WIN_W-1:0] n_q;
    logic [CNT_W-1:0] n_n;
    logic             n_busy;
    logic             n_end;
    logic             n_hold_vld;
    logic [1:0]       n_hold_sym;
    logic             n_out_vld;
    logic [1:0]       n_out_sym;
    logic             n_out_last;

    t_step            step;
    logic [2:0]       take;
    logic [1:0]       sym;
    logic [3:0]       head;
    logic             out_free;
    logic [WIN_W-1:0] pend_q;
    logic [CNT_W-1:0] pend_n;
    logic [WIN_W-1:0] load_q;
    logic [CNT_W-1:0] load_n;

    assign head     = r_q[WIN_W-1 -: 4];
    assign out_free = !r_out_vld || !i_stall;

    // Classify the head of the window
    always_comb begin
        step = STEP_STOP;
        take = 3'd0;
        sym  = SYM_A;
        if (r_n < CNT_W'(2)) begin
            step = STEP_STOP;
        end else begin
            unique case (head[3:2])
                2'b10: begin
                    step = STEP_EMIT; take = 3'd2; sym = SYM_A;
                end
                2'b01: begin
                    step = STEP_EMIT; take = 3'd2; sym = SYM_B;
                end
                2'b00: begin
                    step = STEP_DROP; take = 3'd1;
                end
                default: begin
                    if (r_n == CNT_W'(2)) begin
                        step = STEP_STOP;
                    end else if (!head[1]) begin
                        step = STEP_EMIT; take = 3'd3; sym = SYM_C;
                    end else if (r_n == CNT_W'(3)) begin
                        step = STEP_STOP;
                    end else if (head[0]) begin
                        step = STEP_EMIT; take = 3'd4; sym = SYM_D;
                    end else begin
                        step = STEP_DROP; take = 3'd1;
                    end
                end
            endcase
        end
    end

    // Carried bits and the window for the next byte
    always_comb begin
        if (r_busy && r_end) begin
            pend_q = '0;
            pend_n = '0;
        end else begin
            pend_q = r_q;
            pend_n = r_n;
        end
        load_q = pend_q | ({i_item.packed_byte, {CARRY_W{1'b0}}} >> pend_n[1:0]);
        load_n = {2'b00, pend_n[1:0]} + CNT_W'(BYTE_W);
    end

    // Sequence one decode step per cycle while the output is not stalled
    always_comb begin
        n_q        = r_q;
        n_n        = r_n;
        n_busy     = r_busy;
        n_end      = r_end;
        n_hold_vld = r_hold_vld;
        n_hold_sym = r_hold_sym;
        n_out_vld  = r_out_vld;
        n_out_sym  = r_out_sym;
        n_out_last = r_out_last;
        o_pop      = 1'b0;
        if (out_free) begin
            n_out_vld  = 1'b0;
            n_out_sym  = r_hold_sym;
            n_out_last = 1'b0;
            if (r_busy && step != STEP_STOP) begin
                n_q = r_q << take;
                n_n = r_n - CNT_W'(take);
                if (step == STEP_EMIT) begin
                    n_out_vld  = r_hold_vld;
                    n_hold_vld = 1'b1;
                    n_hold_sym = sym;
                end
            end else begin
                if (r_busy) begin
                    n_out_vld  = r_hold_vld;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                end
                if (i_item_vld) begin
                    o_pop  = 1'b1;
                    n_q    = load_q;
                    n_n    = load_n;
                    n_busy = 1'b1;
                    n_end  = i_item.message_end;
                end else begin
                    n_q    = pend_q;
                    n_n    = pend_n;
                    n_busy = 1'b0;
                end
            end
        end
    end

    // Control and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q        <= '0;
            r_n        <= '0;
            r_busy     <= 1'b0;
            r_end      <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_q        <= n_q;
            r_n        <= n_n;
            r_busy     <= n_busy;
            r_end      <= n_end;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Symbol payload
    always_ff @(posedge i_clk) begin
        r_hold_sym <= n_hold_sym;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_vld;
    assign o_symbol       = r_out_sym;
    assign o_last_of_byte = r_out_last;

endmodule

`default_nettype wire

@@ src/prefix_code_byte_decoder.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_packed_byte[7:0], i_message_end
// output    out        o_valid / i_stall  o_symbol[1:0], o_last_of_byte
//
// The decoder retires one decode step per cycle unless its output stalls: a
// symbol, a dropped bit, or the end of a byte, where the next queued byte is
// loaded in the same cycle.
// Bytes enter a QUEUE_DEPTH-entry queue and are taken while results drain.
// A symbol is held one step so the last one of a byte can be flagged.
// Reset is synchronous; it clears the queue, the carried bits and the output.

module prefix_code_byte_decoder import pcbd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BYTE_W-1:0] i_packed_byte,
    input  wire logic              i_message_end,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_symbol,
    output logic                   o_last_of_byte
);

    t_item item;
    logic  item_vld;
    logic  pop;

    // Accept and queue bytes
    pcbd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_packed_byte (i_packed_byte),
        .i_message_end (i_message_end),
        .o_item        (item),
        .o_item_vld    (item_vld),
        .i_pop         (pop)
    );

    // Decode queued bytes into symbols
    pcbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_item_vld     (item_vld),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol       (o_symbol),
        .o_last_of_byte (o_last_of_byte)
    );

endmodule

`default_nettype wire

@@ src/pcbd_checker.sv @@
`default_nettype none

`include "prefix_code_byte_decoder_defines.svh"

module pcbd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [7:0] i_packed_byte,
    input wire logic       i_message_end,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_symbol,
    input wire logic       o_last_of_byte
);

    logic [8:0] in_word;
    logic [2:0] out_word;

    assign in_word  = {i_packed_byte, i_message_end};
    assign out_word = {o_symbol, o_last_of_byte};

    // A stalled result holds
    `PCBD_ASSERT_NEXT(a_out_hold, i_rst_n && o_valid && i_stall,
        o_valid && $stable(out_word), "stalled result changed")

    // A stalled input transfer holds
    `PCBD_ASSERT_NEXT(a_in_hold, i_rst_n && i_valid && o_stall,
        i_valid && $stable(in_word), "stalled input changed")

    // Reset empties both sides
    `PCBD_ASSERT_NEXT(a_reset_clear, !i_rst_n, !o_valid && !o_stall,
        "reset left a transfer pending")

    // Queue can only fill on an input transfer
    `PCBD_ASSERT_NOW(a_stall_cause, $past(i_rst_n) && i_rst_n && $rose(o_stall),
        $past(i_valid && !o_stall), "input stall rose without a transfer")

endmodule

bind prefix_code_byte_decoder pcbd_checker u_pcbd_checker (.*);

`default_nettype wire

@@ bench/tb_prefix_code_byte_decoder.sv @@
`default_nettype none

module tb_prefix_code_byte_decoder;
    import pcbd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_SYMBOLS  = 5;

    // Codewords, first bit on the left
    localparam logic [1:0] CW_A = 2'b10;
    localparam logic [1:0] CW_B = 2'b01;
    localparam logic [2:0] CW_C = 3'b110;
    localparam logic [3:0] CW_D = 4'b1111;
    localparam logic [3:0] CW_BAD = 4'b1110;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last_of_byte;
    } t_symbol_exp;

    // One directed byte; s holds the typed-in symbols, first one at index 0
    typedef struct packed {
        logic [BYTE_W-1:0] pb;
        logic              fin;
        logic              fixed;
        logic [2:0]        n;
        logic [0:4][1:0]   s;
    } t_row;

    localparam int NUM_ROWS = 22;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_packed_byte = '0;
    logic              i_message_end = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_symbol;
    logic              o_last_of_byte;

    // Carried prefix bits of the predictor
    logic [2:0] carry_bits = '0;
    logic [1:0] carry_count = '0;

    t_symbol_exp expected_symbols [$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_rx = 1'b0;
    event        drain_hold_kick;

    t_row directed_rows [NUM_ROWS] = '{
        '{8'hAA, 1'b1, 1'b1, 3'd4, {SYM_A, SYM_A, SYM_A, SYM_A, SYM_A}},
        '{8'h55, 1'b1, 1'b1, 3'd4, {SYM_B, SYM_B, SYM_B, SYM_B, SYM_A}},
        '{8'hFF, 1'b1, 1'b1, 3'd2, {SYM_D, SYM_D, SYM_A, SYM_A, SYM_A}},
        '{8'h00, 1'b1, 1'b1, 3'd0, {SYM_A, SYM_A, SYM_A, SYM_A, SYM_A}},
        '{8'hD8, 1'b1, 1'b1, 3'd2, {SYM_C, SYM_C, SYM_A, SYM_A, SYM_A}},
        '{8'hE6, 1'b1, 1'b1, 3'd3, {SYM_C, SYM_B, SYM_A, SYM_A, SYM_A}},
        '{8'hAB, 1'b0, 1'b0, 3'd0, '0},
        '{8'h00, 1'b1, 1'b0, 3'd0, '0},
        '{8'hF7, 1'b0, 1'b0, 3'd0, '0},
        '{8'h7F, 1'b0, 1'b0, 3'd0, '0},
        '{8'h01, 1'b0, 1'b0, 3'd0, '0},
        '{8'h80, 1'b0, 1'b0, 3'd0, '0},
        '{8'hFE, 1'b0, 1'b0, 3'd0, '0},
        '{8'h00, 1'b0, 1'b0, 3'd0, '0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, '0},
        '{8'h3F, 1'b1, 1'b0, 3'd0, '0},
        '{8'hE0, 1'b0, 1'b0, 3'd0, '0},
        '{8'h0E, 1'b0, 1'b0, 3'd0, '0},
        '{8'h77, 1'b0, 1'b0, 3'd0, '0},
        '{8'hFF, 1'b1, 1'b0, 3'd0, '0},
        '{8'h6D, 1'b0, 1'b0, 3'd0, '0},
        '{8'hB6, 1'b1, 1'b0, 3'd0, '0}
    };

    prefix_code_byte_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_packed_byte  (i_packed_byte),
        .i_message_end  (i_message_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_symbol       (o_symbol),
        .o_last_of_byte (o_last_of_byte)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Decode one byte behind the carried bits and, if keep is set, queue the symbols it yields
    function automatic void predict_decode(input logic [BYTE_W-1:0] b, input logic fin,
                                           input logic keep);
        logic [10:0] win;
        int unsigned n;
        int unsigned take;
        int unsigned head;
        int          produced;
        logic [1:0]  sym;
        logic [1:0]  syms [MAX_SYMBOLS];
        win = {3'b000, b};
        for (int i = 0; i < carry_count; i++) win[BYTE_W + i] = carry_bits[i];
        n = carry_count + BYTE_W;
        produced = 0;
        while (n >= 2) begin
            take = 0;
            sym = SYM_A;
            head = (win >> (n - 2)) & 3;
            if (head == CW_A) begin
                sym = SYM_A;
                take = 2;
            end else if (head == CW_B) begin
                sym = SYM_B;
                take = 2;
            end else if (head == 0) begin
                // drop the first zero of an invalid pair
                take = 1;
            end else begin
                if (n < 3) break;
                head = (win >> (n - 3)) & 7;
                if (head == CW_C) begin
                    sym = SYM_C;
                    take = 3;
                end else begin
                    if (n < 4) break;
                    head = (win >> (n - 4)) & 15;
                    if (head == CW_D) begin
                        sym = SYM_D;
                        take = 4;
                    end else begin
                        // drop the leading one of an invalid 1110
                        take = 1;
                    end
                end
            end
            if (take >= 2 && produced < MAX_SYMBOLS) begin
                syms[produced] = sym;
                produced++;
            end
            n = n - take;
            win = win & ((11'd1 << n) - 11'd1);
        end
        if (keep) begin
            for (int i = 0; i < produced; i++)
                expected_symbols.push_back(t_symbol_exp'{syms[i], i == produced - 1});
        end
        // Discard leftovers at message end, else carry the undecided prefix
        if (fin || n > 3) begin
            carry_bits = '0;
            carry_count = '0;
        end else begin
            carry_bits = win[2:0];
            carry_count = n[1:0];
        end
    endfunction

    // Offer one byte after random idle cycles and hold it until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin, input logic keep);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_packed_byte <= b;
        i_message_end <= fin;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_decode(b, fin, keep);
        bytes_sent++;
    endtask

    // Encode random symbols, sometimes with an invalid pattern, and pack them
    task automatic send_message(input int nsym);
        bit              code_bits [$];
        logic [BYTE_W-1:0] b;
        int unsigned     pick;
        for (int i = 0; i < nsym; i++) begin
            pick = $urandom_range(3);
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1) == 0) begin
                    code_bits.push_back(1'b0);
                    code_bits.push_back(1'b0);
                end else begin
                    for (int k = 3; k >= 0; k--) code_bits.push_back(CW_BAD[k]);
                end
            end
            case (pick)
                SYM_A: for (int k = 1; k >= 0; k--) code_bits.push_back(CW_A[k]);
                SYM_B: for (int k = 1; k >= 0; k--) code_bits.push_back(CW_B[k]);
                SYM_C: for (int k = 2; k >= 0; k--) code_bits.push_back(CW_C[k]);
                default: for (int k = 3; k >= 0; k--) code_bits.push_back(CW_D[k]);
            endcase
        end
        // Pad the final byte with random bits
        while (code_bits.size() != 0) begin
            for (int j = BYTE_W - 1; j >= 0; j--) begin
                if (code_bits.size() != 0) b[j] = code_bits.pop_front();
                else b[j] = 1'($urandom_range(1));
            end
            send_byte(b, code_bits.size() == 0, 1'b1);
        end
    endtask

    // Mostly well-formed messages, the rest stray bytes
    task automatic run_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 80)
                send_message($urandom_range(10, 1));
            else
                send_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0, 1'b1);
        end
    endtask

    // Drop valid and wait for the expected symbols to drain
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_symbols.size() != 0);
    endtask

    task automatic note_mismatch(input logic [1:0] want_sym, input logic want_last,
                                 input logic unexpected);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (unexpected)
                $display("unexpected symbol %0d last %0b", o_symbol, o_last_of_byte);
            else
                $display("mismatch: expected symbol %0d last %0b, got symbol %0d last %0b",
                         want_sym, want_last, o_symbol, o_last_of_byte);
        end
    endtask

    // Drive the receiver stall: random idling plus the long hold-off
    always @(posedge i_clk) begin
        i_stall <= hold_rx || ($urandom_range(99) < rx_idle_pct);
    end

    // Count out the long hold-off once kicked
    initial begin
        forever begin
            @(drain_hold_kick);
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_rx <= 1'b0;
        end
    end

    // Compare each output transfer with the oldest expected symbol
    always @(posedge i_clk) begin : check_symbols
        t_symbol_exp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_symbols.size() == 0) begin
                note_mismatch(2'b00, 1'b0, 1'b1);
            end else begin
                want = expected_symbols.pop_front();
                if (o_symbol !== want.symbol || o_last_of_byte !== want.last_of_byte)
                    note_mismatch(want.symbol, want.last_of_byte, 1'b0);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_prefix_code_byte_decoder: FAIL");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily
        tx_idle_pct = 27;
        rx_idle_pct <= 83;
        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].pb, directed_rows[r].fin, !directed_rows[r].fixed);
            if (directed_rows[r].fixed) begin
                for (int k = 0; k < directed_rows[r].n; k++)
                    expected_symbols.push_back(t_symbol_exp'{directed_rows[r].s[k],
                                                             k == directed_rows[r].n - 1});
            end
        end
        run_random(60);
        wait_for_drain();

        // Swap the idling sides
        tx_idle_pct = 83;
        rx_idle_pct <= 27;
        run_random(60);
        wait_for_drain();

        // No idling; hold the receiver off while bytes keep coming
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        -> drain_hold_kick;
        repeat (16) send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        wait_for_drain();
        run_random(60);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_symbols.size() == 0)
            $display("tb_prefix_code_byte_decoder: PASS");
        else
            $display("tb_prefix_code_byte_decoder: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/pcbd_pkg.sv
src/pcbd_front.sv
src/pcbd_back.sv
src/prefix_code_byte_decoder.sv
src/pcbd_checker.sv
bench/tb_prefix_code_byte_decoder.sv
